[src/fpba_pkg.sv]
// Shared types and constants for the fenced page bump allocator.
// Holds the request and result beat structs and the shared adder interface.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fpba_pkg;

    localparam int FENCE_W = 48;
    localparam int SIZE_W  = 32;
    localparam int ALIGN_W = 5;
    localparam int OFFS_W  = 25;
    localparam int ASIZE_W = 33;
    localparam int PIDX_W  = 6;
    localparam int ALU_W   = 48;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_CLEANUP = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_PLACED  = 2'd0,
        ST_LARGE   = 2'd1,
        ST_NO_PAGE = 2'd2,
        ST_CLEANED = 2'd3
    } t_status;

    typedef struct packed {
        t_op                  operation;
        logic [SIZE_W-1:0]    size_bytes;
        logic [ALIGN_W-1:0]   align_log2;
        logic [FENCE_W-1:0]   fence_value;
        logic [FENCE_W-1:0]   completed_fence;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [PIDX_W-1:0]    page_index;
        logic [OFFS_W-1:0]    offset;
        logic [ASIZE_W-1:0]   aligned_size;
    } t_res;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        t_alu_op              op;
        logic [ALU_W-1:0]     a;
        logic [ALU_W-1:0]     b;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W:0]       sum;
        logic                 lt;
    } t_alu_rsp;

endpackage

`default_nettype wire

[src/fpba_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fpba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                     i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[src/fpba_alu.sv]
// Shared 48-bit adder/subtractor used by the allocator sequencer.
// Depends on fpba_pkg for the request and response structs.
`timescale 1ns / 1ps
`default_nettype none

module fpba_alu (
    input  fpba_pkg::t_alu_req i_req,
    output fpba_pkg::t_alu_rsp o_rsp
);

    import fpba_pkg::*;

    logic           sub;
    logic [ALU_W:0] b_ext;
    logic [ALU_W:0] sum;

    assign sub   = (i_req.op == ALU_SUB);
    assign b_ext = sub ? ~{1'b0, i_req.b} : {1'b0, i_req.b};
    assign sum   = {1'b0, i_req.a} + b_ext + {{ALU_W{1'b0}}, sub};

    // For a subtract the top bit of the 49-bit difference is set exactly when a < b.
    assign o_rsp.sum = sum;
    assign o_rsp.lt  = sub & sum[ALU_W];

endmodule

`default_nettype wire

[src/fenced_page_bump_allocator.sv]
// Fenced page bump allocator: a sequencer drives one shared 48-bit adder through a series of states.
// Steps: the size is aligned and checked against the page (a large request ends here), the
// offset is aligned and the end checked for a fit in the open page, else the open page is retired,
// completed pending pages are recycled and a free or new page is taken. Cleanup moves in-use pages to pending.
// One item at a time; busy is high until the result strobe. The receiver cannot stall.
// Reset is synchronous, active low: control state clears, page_size returns to 65536.
`timescale 1ns / 1ps
`default_nettype none

module fenced_page_bump_allocator #(
    parameter int MAX_PAGES = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  fpba_pkg::t_req         i_req,
    output logic                   o_res_strobe,
    output fpba_pkg::t_res         o_res,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [24:0]       i_cfg_data
);

    import fpba_pkg::*;

    localparam int PW  = $clog2(MAX_PAGES);
    localparam int CW  = $clog2(MAX_PAGES + 1);
    localparam int PXW = PW + PIDX_W;
    localparam int QW  = FENCE_W + PW;
    localparam logic [CW-1:0] MAXC = CW'(MAX_PAGES);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_ASIZE = 13'b0000000000010,
        S_LARGE = 13'b0000000000100,
        S_OFF   = 13'b0000000001000,
        S_END   = 13'b0000000010000,
        S_FIT   = 13'b0000000100000,
        S_DRD   = 13'b0000001000000,
        S_DCHK  = 13'b0000010000000,
        S_POP   = 13'b0000100000000,
        S_POPW  = 13'b0001000000000,
        S_KRET  = 13'b0010000000000,
        S_KRD   = 13'b0100000000000,
        S_KWR   = 13'b1000000000000
    } t_state;

    // Control state
    t_state             r_state, n_state;
    logic [OFFS_W-1:0]  r_page_size, n_page_size;
    logic               r_page_open, n_page_open;
    logic [PW-1:0]      r_open_page, n_open_page;
    logic [OFFS_W-1:0]  r_fill, n_fill;
    logic [CW-1:0]      r_in_use_cnt, n_in_use_cnt;
    logic [PW-1:0]      r_free_head, n_free_head;
    logic [CW-1:0]      r_free_cnt, n_free_cnt;
    logic [PW-1:0]      r_pend_head, n_pend_head;
    logic [CW-1:0]      r_pend_cnt, n_pend_cnt;
    logic [CW-1:0]      r_pages_made, n_pages_made;
    logic [CW-1:0]      r_idx, n_idx;
    logic               r_res_strobe, n_res_strobe;

    // Working registers of the current item
    logic [SIZE_W-1:0]  r_size, n_size;
    logic [31:0]        r_mask, n_mask;
    logic [FENCE_W-1:0] r_fence, n_fence;
    logic [FENCE_W-1:0] r_done, n_done;
    logic [ASIZE_W-1:0] r_asize, n_asize;
    logic [ASIZE_W-1:0] r_off, n_off;
    logic [ASIZE_W:0]   r_end, n_end;
    t_res               r_res, n_res;

    t_alu_req           alu_req;
    t_alu_rsp           alu_rsp;

    logic               iu_we;
    logic [PW-1:0]      iu_waddr, iu_raddr, iu_wdata, iu_rdata;
    logic               fq_we;
    logic [PW-1:0]      fq_waddr, fq_raddr, fq_wdata, fq_rdata;
    logic               pq_we;
    logic [PW-1:0]      pq_waddr, pq_raddr;
    logic [QW-1:0]      pq_wdata, pq_rdata;

    logic [PW-1:0]      free_tail, pend_tail;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(MAX_PAGES - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] head,
                                              input logic [CW-1:0] cnt);
        logic [PW:0] s;
        s = {1'b0, head} + (PW+1)'(cnt);
        if (s >= (PW+1)'(MAX_PAGES)) begin
            s = s - (PW+1)'(MAX_PAGES);
        end
        ptr_add = s[PW-1:0];
    endfunction

    function automatic logic [PIDX_W-1:0] to_pidx(input logic [PW-1:0] p);
        logic [PXW-1:0] ext;
        ext     = PXW'(p);
        to_pidx = ext[PIDX_W-1:0];
    endfunction

    assign free_tail = ptr_add(r_free_head, r_free_cnt);
    assign pend_tail = ptr_add(r_pend_head, r_pend_cnt);

    fpba_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    fpba_ram #(.WIDTH(PW), .DEPTH(MAX_PAGES)) u_in_use_ram (
        .i_clk   (i_clk),
        .i_we    (iu_we),
        .i_waddr (iu_waddr),
        .i_wdata (iu_wdata),
        .i_raddr (iu_raddr),
        .o_rdata (iu_rdata)
    );

    fpba_ram #(.WIDTH(PW), .DEPTH(MAX_PAGES)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (fq_we),
        .i_waddr (fq_waddr),
        .i_wdata (fq_wdata),
        .i_raddr (fq_raddr),
        .o_rdata (fq_rdata)
    );

    fpba_ram #(.WIDTH(QW), .DEPTH(MAX_PAGES)) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (pq_we),
        .i_waddr (pq_waddr),
        .i_wdata (pq_wdata),
        .i_raddr (pq_raddr),
        .o_rdata (pq_rdata)
    );

    // Operand selection for the shared adder.
    always_comb begin
        alu_req.op = ALU_ADD;
        alu_req.a  = '0;
        alu_req.b  = '0;
        case (r_state)
            S_ASIZE: begin
                alu_req.a = ALU_W'(r_size);
                alu_req.b = ALU_W'(r_mask);
            end
            S_LARGE: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = ALU_W'(r_page_size);
                alu_req.b  = ALU_W'(r_asize);
            end
            S_OFF: begin
                alu_req.a = ALU_W'(r_fill);
                alu_req.b = ALU_W'(r_mask);
            end
            S_END: begin
                alu_req.a = ALU_W'(r_off);
                alu_req.b = ALU_W'(r_asize);
            end
            S_FIT: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = ALU_W'(r_page_size);
                alu_req.b  = ALU_W'(r_end);
            end
            S_DCHK: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = r_done;
                alu_req.b  = pq_rdata[QW-1:PW];
            end
            default: begin
                alu_req.op = ALU_ADD;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_page_size  = r_page_size;
        n_page_open  = r_page_open;
        n_open_page  = r_open_page;
        n_fill       = r_fill;
        n_in_use_cnt = r_in_use_cnt;
        n_free_head  = r_free_head;
        n_free_cnt   = r_free_cnt;
        n_pend_head  = r_pend_head;
        n_pend_cnt   = r_pend_cnt;
        n_pages_made = r_pages_made;
        n_idx        = r_idx;
        n_res_strobe = 1'b0;
        n_size       = r_size;
        n_mask       = r_mask;
        n_fence      = r_fence;
        n_done       = r_done;
        n_asize      = r_asize;
        n_off        = r_off;
        n_end        = r_end;
        n_res        = r_res;

        iu_we    = 1'b0;
        iu_waddr = r_in_use_cnt[PW-1:0];
        iu_wdata = r_open_page;
        iu_raddr = r_idx[PW-1:0];
        fq_we    = 1'b0;
        fq_waddr = free_tail;
        fq_wdata = pq_rdata[PW-1:0];
        fq_raddr = r_free_head;
        pq_we    = 1'b0;
        pq_waddr = pend_tail;
        pq_wdata = {r_fence, iu_rdata};
        pq_raddr = r_pend_head;

        case (r_state)
            S_IDLE: begin
                if (i_cfg_valid) begin
                    n_page_size = i_cfg_data;
                end
                if (start) begin
                    n_size  = i_req.size_bytes;
                    n_mask  = ~(32'hFFFF_FFFF << i_req.align_log2);
                    n_fence = i_req.fence_value;
                    n_done  = i_req.completed_fence;
                    n_state = (i_req.operation == OP_CLEANUP) ? S_KRET : S_ASIZE;
                end
            end
            S_ASIZE: begin
                n_asize = alu_rsp.sum[ASIZE_W-1:0] & ~{1'b0, r_mask};
                n_state = S_LARGE;
            end
            S_LARGE: begin
                if (alu_rsp.lt) begin
                    n_res.status       = ST_LARGE;
                    n_res.page_index   = '0;
                    n_res.offset       = '0;
                    n_res.aligned_size = r_asize;
                    n_res_strobe       = 1'b1;
                    n_state            = S_IDLE;
                end else begin
                    n_state = S_OFF;
                end
            end
            S_OFF: begin
                n_off   = alu_rsp.sum[ASIZE_W-1:0] & ~{1'b0, r_mask};
                n_state = S_END;
            end
            S_END: begin
                n_end   = alu_rsp.sum[ASIZE_W:0];
                n_state = S_FIT;
            end
            S_FIT: begin
                if (r_page_open && !alu_rsp.lt) begin
                    n_fill             = r_end[OFFS_W-1:0];
                    n_res.status       = ST_PLACED;
                    n_res.page_index   = to_pidx(r_open_page);
                    n_res.offset       = r_off[OFFS_W-1:0];
                    n_res.aligned_size = r_asize;
                    n_res_strobe       = 1'b1;
                    n_state            = S_IDLE;
                end else begin
                    // The open page overflowed (or none was open): retire it and find another.
                    if (r_page_open && (r_in_use_cnt < MAXC)) begin
                        iu_we        = 1'b1;
                        n_in_use_cnt = r_in_use_cnt + 1'b1;
                    end
                    n_page_open = 1'b0;
                    n_state     = S_DRD;
                end
            end
            S_DRD: begin
                n_state = (r_pend_cnt != '0) ? S_DCHK : S_POP;
            end
            S_DCHK: begin
                if (!alu_rsp.lt) begin
                    if (r_free_cnt < MAXC) begin
                        fq_we      = 1'b1;
                        n_free_cnt = r_free_cnt + 1'b1;
                    end
                    n_pend_head = ptr_inc(r_pend_head);
                    n_pend_cnt  = r_pend_cnt - 1'b1;
                    n_state     = S_DRD;
                end else begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (r_free_cnt != '0) begin
                    n_state = S_POPW;
                end else if (r_pages_made < MAXC) begin
                    n_open_page        = r_pages_made[PW-1:0];
                    n_pages_made       = r_pages_made + 1'b1;
                    n_page_open        = 1'b1;
                    n_fill             = r_asize[OFFS_W-1:0];
                    n_res.status       = ST_PLACED;
                    n_res.page_index   = to_pidx(r_pages_made[PW-1:0]);
                    n_res.offset       = '0;
                    n_res.aligned_size = r_asize;
                    n_res_strobe       = 1'b1;
                    n_state            = S_IDLE;
                end else begin
                    n_fill             = '0;
                    n_res.status       = ST_NO_PAGE;
                    n_res.page_index   = '0;
                    n_res.offset       = '0;
                    n_res.aligned_size = r_asize;
                    n_res_strobe       = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            S_POPW: begin
                n_open_page        = fq_rdata;
                n_free_head        = ptr_inc(r_free_head);
                n_free_cnt         = r_free_cnt - 1'b1;
                n_page_open        = 1'b1;
                n_fill             = r_asize[OFFS_W-1:0];
                n_res.status       = ST_PLACED;
                n_res.page_index   = to_pidx(fq_rdata);
                n_res.offset       = '0;
                n_res.aligned_size = r_asize;
                n_res_strobe       = 1'b1;
                n_state            = S_IDLE;
            end
            S_KRET: begin
                if (r_page_open && (r_in_use_cnt < MAXC)) begin
                    iu_we        = 1'b1;
                    n_in_use_cnt = r_in_use_cnt + 1'b1;
                end
                n_page_open = 1'b0;
                n_fill      = '0;
                n_idx       = '0;
                n_state     = S_KRD;
            end
            S_KRD: begin
                if (r_idx == r_in_use_cnt) begin
                    n_in_use_cnt       = '0;
                    n_res.status       = ST_CLEANED;
                    n_res.page_index   = '0;
                    n_res.offset       = '0;
                    n_res.aligned_size = '0;
                    n_res_strobe       = 1'b1;
                    n_state            = S_IDLE;
                end else begin
                    n_state = S_KWR;
                end
            end
            S_KWR: begin
                if (r_pend_cnt < MAXC) begin
                    pq_we      = 1'b1;
                    n_pend_cnt = r_pend_cnt + 1'b1;
                end
                n_idx   = r_idx + 1'b1;
                n_state = S_KRD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_page_size  <= OFFS_W'(65536);
            r_page_open  <= 1'b0;
            r_open_page  <= '0;
            r_fill       <= '0;
            r_in_use_cnt <= '0;
            r_free_head  <= '0;
            r_free_cnt   <= '0;
            r_pend_head  <= '0;
            r_pend_cnt   <= '0;
            r_pages_made <= '0;
            r_idx        <= '0;
            r_res_strobe <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_page_size  <= n_page_size;
            r_page_open  <= n_page_open;
            r_open_page  <= n_open_page;
            r_fill       <= n_fill;
            r_in_use_cnt <= n_in_use_cnt;
            r_free_head  <= n_free_head;
            r_free_cnt   <= n_free_cnt;
            r_pend_head  <= n_pend_head;
            r_pend_cnt   <= n_pend_cnt;
            r_pages_made <= n_pages_made;
            r_idx        <= n_idx;
            r_res_strobe <= n_res_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size  <= n_size;
        r_mask  <= n_mask;
        r_fence <= n_fence;
        r_done  <= n_done;
        r_asize <= n_asize;
        r_off   <= n_off;
        r_end   <= n_end;
        r_res   <= n_res;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_cfg_ready  = (r_state == S_IDLE);
    assign o_res_strobe = r_res_strobe;
    assign o_res        = r_res;

`ifndef ASSERT_OFF
    // A result beat is only ever presented once the sequencer is back to idle.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> !busy)
        else $error("result beat while sequencer busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start the sequencer");

    // Every page index ever made sits in exactly one place between items.
    a_page_conservation: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |->
        (({2'b00, r_free_cnt} + {2'b00, r_pend_cnt} + {2'b00, r_in_use_cnt}
          + (CW+2)'(r_page_open)) == {2'b00, r_pages_made}))
        else $error("page accounting lost or duplicated a page");

    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free_cnt <= MAXC) && (r_pend_cnt <= MAXC) && (r_pages_made <= MAXC)
        && (r_in_use_cnt <= MAXC))
        else $error("queue count above page capacity");
`endif

endmodule

`default_nettype wire

[tb/tb_fenced_page_bump_allocator.sv]
// Self-checking testbench for the fenced page bump allocator.
// Predicts every result from its own page, queue and fence bookkeeping.
// Depends on fpba_pkg and fenced_page_bump_allocator.
`timescale 1ns / 1ps

module tb_fenced_page_bump_allocator;

    import fpba_pkg::*;

    localparam int PAGE_LIMIT = 64;
    localparam int DRAIN_CYCLES = 20;

    // Tracks the allocator's pages, queues and fill point and holds the results due.
    class allocation_tracker;
        logic [24:0] page_size;
        bit          page_open;
        logic [5:0]  open_page;
        logic [24:0] fill_offset;
        logic [5:0]  in_use_pages[PAGE_LIMIT];
        int unsigned in_use_count;
        logic [5:0]  free_pages[PAGE_LIMIT];
        int unsigned free_head, free_count;
        logic [47:0] pend_fence[PAGE_LIMIT];
        logic [5:0]  pend_page[PAGE_LIMIT];
        int unsigned pend_head, pend_count;
        int unsigned pages_made;
        t_res        results_due[$];
        int unsigned mismatches;

        function new();
            page_size    = 25'd65536;
            page_open    = 1'b0;
            open_page    = '0;
            fill_offset  = '0;
            in_use_count = 0;
            free_head    = 0;
            free_count   = 0;
            pend_head    = 0;
            pend_count   = 0;
            pages_made   = 0;
            mismatches   = 0;
        endfunction

        function void queue_result(input t_res want);
            results_due.insert(results_due.size(), want);
        endfunction

        function void retire_open_page();
            if (page_open && in_use_count < PAGE_LIMIT) begin
                in_use_pages[in_use_count] = open_page;
                in_use_count++;
            end
            page_open = 1'b0;
        endfunction

        // Recycles pending pages in order while their fences have completed, then takes a page.
        function bit take_page(input logic [47:0] done, output logic [5:0] page);
            page = '0;
            while (pend_count > 0 && pend_fence[pend_head] <= done) begin
                if (free_count < PAGE_LIMIT) begin
                    free_pages[(free_head + free_count) % PAGE_LIMIT] = pend_page[pend_head];
                    free_count++;
                end
                pend_head = (pend_head + 1) % PAGE_LIMIT;
                pend_count--;
            end
            if (free_count > 0) begin
                page = free_pages[free_head];
                free_head = (free_head + 1) % PAGE_LIMIT;
                free_count--;
                return 1'b1;
            end
            if (pages_made < PAGE_LIMIT) begin
                page = pages_made[5:0];
                pages_made++;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_request(input t_req r);
            t_res        want;
            logic [63:0] mask, asize, off;
            logic [5:0]  page;
            int unsigned i, slot;
            want = '0;
            want.status = ST_PLACED;
            if (r.operation == OP_CLEANUP) begin
                retire_open_page();
                fill_offset = '0;
                for (i = 0; i < in_use_count; i++) begin
                    if (pend_count < PAGE_LIMIT) begin
                        slot = (pend_head + pend_count) % PAGE_LIMIT;
                        pend_fence[slot] = r.fence_value;
                        pend_page[slot]  = in_use_pages[i];
                        pend_count++;
                    end
                end
                in_use_count = 0;
                want.status = ST_CLEANED;
                queue_result(want);
                return;
            end
            mask  = (64'd1 << r.align_log2) - 64'd1;
            asize = ({32'd0, r.size_bytes} + mask) & ~mask;
            want.aligned_size = asize[32:0];
            if (asize > {39'd0, page_size}) begin
                want.status = ST_LARGE;
                queue_result(want);
                return;
            end
            off = ({39'd0, fill_offset} + mask) & ~mask;
            if (off + asize > {39'd0, page_size}) begin
                retire_open_page();
                off = '0;
            end
            if (!page_open) begin
                off = '0;
                if (!take_page(r.completed_fence, page)) begin
                    fill_offset = '0;
                    want.status = ST_NO_PAGE;
                    queue_result(want);
                    return;
                end
                open_page = page;
                page_open = 1'b1;
            end
            fill_offset = off[24:0] + asize[24:0];
            want.page_index = open_page;
            want.offset = off[24:0];
            queue_result(want);
        endfunction

        function void check_result(input t_res got);
            t_res want;
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result beat: status %0d page %0d offset %0d size %0d",
                         $time, got.status, got.page_index, got.offset, got.aligned_size);
                mismatches++;
                return;
            end
            want = results_due.pop_front();
            if (got !== want) begin
                $display("%0t: mismatch: expected status %0d page %0d offset %0d size %0d",
                         $time, want.status, want.page_index, want.offset, want.aligned_size);
                $display("%0t:           actual status %0d page %0d offset %0d size %0d",
                         $time, got.status, got.page_index, got.offset, got.aligned_size);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_req        i_req;
    logic        o_res_strobe;
    t_res        o_res;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [24:0] i_cfg_data;

    allocation_tracker tracker;
    logic [47:0] fence_issued;
    logic [47:0] fence_acked;

    fenced_page_bump_allocator #(
        .MAX_PAGES(PAGE_LIMIT)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_strobe(o_res_strobe),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_strobe) begin
            tracker.check_result(o_res);
        end
    end

    function automatic logic [47:0] random_fence();
        logic [63:0] wide;
        wide = {$urandom(), $urandom()};
        return wide[47:0];
    endfunction

    function automatic t_req make_req(input t_op op, input logic [31:0] size,
                                      input logic [4:0] align, input logic [47:0] fence,
                                      input logic [47:0] done);
        t_req r;
        r.operation       = op;
        r.size_bytes      = size;
        r.align_log2      = align;
        r.fence_value     = fence;
        r.completed_fence = done;
        return r;
    endfunction

    // Mostly well-formed traffic: sizes scaled to the page, fences that rise, and a
    // completion point that lags behind so pages pile up and run out.
    function automatic t_req random_request(input int catch_pct);
        t_req        r;
        logic [31:0] ps;
        int unsigned pick;
        ps = {7'd0, tracker.page_size};
        r.operation   = OP_ALLOC;
        r.fence_value = random_fence();
        if ($urandom_range(99) < catch_pct) begin
            fence_acked = fence_issued;
        end
        pick = $urandom_range(99);
        if (pick < 88) begin
            r.completed_fence = fence_acked;
        end else if (pick < 94) begin
            r.completed_fence = '0;
        end else if (pick < 98) begin
            r.completed_fence = random_fence();
        end else begin
            r.completed_fence = '1;
        end
        if ($urandom_range(99) < 8) begin
            r.operation   = OP_CLEANUP;
            r.size_bytes  = $urandom();
            r.align_log2  = 5'($urandom_range(31));
            if ($urandom_range(99) >= 10) begin
                fence_issued  = fence_issued + $urandom_range(3, 1);
                r.fence_value = fence_issued;
            end
            return r;
        end
        case ($urandom_range(9))
            0, 1, 2, 3: r.size_bytes = $urandom_range(ps / 4);
            4, 5:       r.size_bytes = $urandom_range(ps);
            6:          r.size_bytes = ps + $urandom_range(2) - 1;
            7:          r.size_bytes = $urandom_range(64);
            default:    r.size_bytes = $urandom();
        endcase
        case ($urandom_range(9))
            7, 8:    r.align_log2 = 5'($urandom_range(16));
            9:       r.align_log2 = 5'($urandom_range(31));
            default: r.align_log2 = 5'($urandom_range(6));
        endcase
        return r;
    endfunction

    task automatic wait_for_results();
        while (tracker.results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_request(input t_req r, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        i_req <= r;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        tracker.note_request(r);
    endtask

    // The sender holds off until every result is back, so the write lands on an idle block.
    task automatic write_page_size(input logic [24:0] value);
        wait_for_results();
        while (busy) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        tracker.page_size = value;
    endtask

    task automatic run_phase(input logic [24:0] ps, input int idle_pct, input int count,
                             input int catch_pct);
        write_page_size(ps);
        repeat (count) send_request(random_request(catch_pct), idle_pct);
        start <= 1'b0;
    endtask

    task automatic run_directed();
        // Opening page, alignment, overflow onto a fresh page, large requests at 32 bits.
        send_request(make_req(OP_ALLOC, 32'd0, 5'd0, 48'd0, 48'd0), 0);
        send_request(make_req(OP_ALLOC, 32'd100, 5'd4, 48'd0, 48'd0), 0);
        send_request(make_req(OP_ALLOC, 32'd65536, 5'd0, 48'd0, 48'd0), 0);
        send_request(make_req(OP_ALLOC, 32'd65537, 5'd0, 48'd0, 48'd0), 0);
        send_request(make_req(OP_ALLOC, 32'hFFFF_FFFF, 5'd31, '1, '1), 0);
        send_request(make_req(OP_ALLOC, 32'd1, 5'd16, 48'd0, 48'd0), 0);
        send_request(make_req(OP_ALLOC, 32'd3, 5'd31, 48'd0, 48'd0), 0);
        // Cleanup, then recycling once the fence is reached.
        send_request(make_req(OP_CLEANUP, 32'hFFFF_FFFF, 5'd31, 48'd5, 48'd0), 0);
        send_request(make_req(OP_ALLOC, 32'd10, 5'd0, 48'd0, 48'd4), 0);
        send_request(make_req(OP_ALLOC, 32'd65536, 5'd0, 48'd0, 48'd5), 0);
        send_request(make_req(OP_ALLOC, 32'd7, 5'd5, 48'd0, 48'd0), 0);
        send_request(make_req(OP_CLEANUP, 32'd0, 5'd0, '1, 48'd0), 0);
        send_request(make_req(OP_ALLOC, 32'd8, 5'd3, 48'd0, '1), 0);
        send_request(make_req(OP_ALLOC, 32'h8000_0000, 5'd0, 48'd0, 48'd0), 0);
        send_request(make_req(OP_ALLOC, 32'd65535, 5'd1, 48'd0, 48'd0), 0);
        send_request(make_req(OP_CLEANUP, 32'h5555_5555, 5'd21, 48'hAAAA_5555_AAAA, '1), 0);
        send_request(make_req(OP_ALLOC, 32'h5555_5555, 5'd21, 48'd0, 48'h5555_AAAA_5555), 0);
        send_request(make_req(OP_ALLOC, 32'd0, 5'd31, 48'd0, '1), 0);
        start <= 1'b0;
    endtask

    initial begin
        #12_000_000;
        $display("tb_fenced_page_bump_allocator: FAIL");
        $finish;
    end

    initial begin
        tracker      = new();
        fence_issued = 48'd16;
        fence_acked  = 48'd0;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_req       <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_phase(25'd256, 0, 150, 10);
        run_phase(25'd4096, 69, 150, 5);
        run_phase(25'd1, 0, 100, 10);
        run_phase(25'd16777216, 34, 130, 10);
        // Small pages and a stalled completion point drive the pool to exhaustion.
        run_phase(25'd64, 0, 200, 1);
        run_phase(25'd0, 69, 60, 10);
        run_phase(25'h1FF_FFFF, 0, 80, 10);
        run_phase(25'($urandom_range(65536, 2)), 34, 150, 5);
        run_phase(25'd1024, 0, 100, 20);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.results_due.size() == 0) begin
            $display("tb_fenced_page_bump_allocator: PASS");
        end else begin
            $display("tb_fenced_page_bump_allocator: FAIL");
        end
        $finish;
    end

endmodule

[files.f]
src/fpba_pkg.sv
src/fpba_ram.sv
src/fpba_alu.sv
src/fenced_page_bump_allocator.sv
tb/tb_fenced_page_bump_allocator.sv
